### design/sorted_replay_window_check_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted replay window check unit
// Clocked property checks with a reset disable guard; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_REPLAY_WINDOW_CHECK_UNIT_ASSERT_SVH
`define SORTED_REPLAY_WINDOW_CHECK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// check a property at every rising edge outside reset
`define SRWC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("srwc check failed");
// check that a condition never holds outside reset
`define SRWC_NEVER(lbl, clk, rst, cond) \
  `SRWC_ASSERT(lbl, clk, rst, !(cond))
`else
`define SRWC_ASSERT(lbl, clk, rst, prop)
`define SRWC_NEVER(lbl, clk, rst, cond)
`endif
`endif

### design/srwc_pkg.sv
// ----------------------------------------------------------------------------
// srwc_pkg
// Shared constants, verdict codes, ring pointer helpers and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package srwc_pkg;

  localparam int WINDOW_ENTRIES = 64;
  localparam int PTR_W = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
  localparam int ID_W = 64;
  localparam int TIME_W = 32;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_ENTRIES - 1);
  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(60);

  typedef enum logic [2:0] {
    VERDICT_NEWEST       = 3'd0,
    VERDICT_OUT_OF_ORDER = 3'd1,
    VERDICT_STALE        = 3'd2,
    VERDICT_DUPLICATE    = 3'd3,
    VERDICT_TOO_OLD      = 3'd4
  } verdict_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic     ptr_newest;
    logic     ptr_dec;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     save_ins;
    logic     shift_wr;
    logic     ins_wr;
    logic     finish;
    logic     ok;
    verdict_t verdict;
  } srwc_cmd_t;

  typedef struct packed {
    logic stale;
    logic gt;
    logic eq;
    logic cnt_zero;
    logic cnt_last;
    logic first_hit;
  } srwc_stat_t;

  function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

endpackage

### design/sorted_replay_window_check_unit.sv
// ----------------------------------------------------------------------------
// sorted_replay_window_check_unit
// Anti-replay check over a sorted ring of recent packet ids with an optional
// timestamp window.
//
//   channel   signals                          handshake
//   -------   ------------------------------   --------------------------
//   command   sequence_id, now_time            start high, busy low
//   result    accepted, verdict                done strobe, one cycle
//   config    cfg_data (window_seconds)        cfg_we, written at once
//
// A packet passes the timestamp check, a backward scan of older ring entries,
// a shift of each newer entry and the final write; stale, duplicate and too-old
// packets end early. The ring memory has a registered read port.
// The result word is registered after the last step and strobed by done.
// Reset clears the ring through per-entry valid bits, no clearing pass.
// Results cannot be held off; a new command may be taken while done is high.
// ----------------------------------------------------------------------------
module sorted_replay_window_check_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [srwc_pkg::ID_W-1:0]   sequence_id,
  input  logic [srwc_pkg::TIME_W-1:0] now_time,
  output logic                        done,
  output logic                        accepted,
  output logic [2:0]                  verdict,
  input  logic                        cfg_we,
  input  logic [srwc_pkg::TIME_W-1:0] cfg_data
);
  import srwc_pkg::*;

  srwc_cmd_t  cmd;
  srwc_stat_t stat;

  srwc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  srwc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .sequence_id (sequence_id),
    .now_time    (now_time),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .accepted    (accepted),
    .verdict     (verdict)
  );

endmodule

### design/srwc_ctrl.sv
// ----------------------------------------------------------------------------
// srwc_ctrl
// Sequencer: timestamp check, backward scan of the ring, shift of the newer
// entries and insertion, then one result word.
// ----------------------------------------------------------------------------
`include "sorted_replay_window_check_unit_assert.svh"

module srwc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  srwc_pkg::srwc_stat_t stat,
  output srwc_pkg::srwc_cmd_t  cmd,
  output logic                 busy
);
  import srwc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TCHK   = 7'b0000010,
    S_SC_RD  = 7'b0000100,
    S_SC_CMP = 7'b0001000,
    S_SH_RD  = 7'b0010000,
    S_SH_WR  = 7'b0100000,
    S_INS    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.verdict = VERDICT_NEWEST;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_TCHK;
        end
      end
      S_TCHK: begin
        if (stat.stale) begin
          cmd.finish  = 1'b1;
          cmd.verdict = VERDICT_STALE;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SC_CMP;
        end
      end
      S_SC_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SC_CMP;
      end
      S_SC_CMP: begin
        priority if (stat.eq) begin
          cmd.finish  = 1'b1;
          cmd.verdict = VERDICT_DUPLICATE;
          state_next  = S_IDLE;
        end else if (stat.gt) begin
          // remember the insertion point, restart from the newest for the shift
          cmd.save_ins   = 1'b1;
          cmd.ptr_newest = 1'b1;
          state_next     = S_SH_RD;
        end else if (stat.cnt_last) begin
          cmd.finish  = 1'b1;
          cmd.verdict = VERDICT_TOO_OLD;
          state_next  = S_IDLE;
        end else begin
          cmd.ptr_dec = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_SC_RD;
        end
      end
      S_SH_RD: begin
        if (stat.cnt_zero) begin
          state_next = S_INS;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.ptr_dec  = 1'b1;
        cmd.cnt_dec  = 1'b1;
        state_next   = S_SH_RD;
      end
      S_INS: begin
        cmd.ins_wr  = 1'b1;
        cmd.finish  = 1'b1;
        cmd.ok      = 1'b1;
        cmd.verdict = stat.first_hit ? VERDICT_NEWEST : VERDICT_OUT_OF_ORDER;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SRWC_ASSERT(a_load_to_tchk, clk, rst, cmd.load |=> (state == S_TCHK))
  `SRWC_NEVER(a_shift_on_empty, clk, rst, cmd.shift_wr && stat.cnt_zero)
  `SRWC_ASSERT(a_ok_only_on_insert, clk, rst, (cmd.finish && cmd.ok) |-> cmd.ins_wr)

endmodule

### design/srwc_dp.sv
// ----------------------------------------------------------------------------
// srwc_dp
// Window register, id and time difference latches, the id ring memory with
// its valid bits, scan pointers and the result register.
// ----------------------------------------------------------------------------
`include "sorted_replay_window_check_unit_assert.svh"

module srwc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [srwc_pkg::TIME_W-1:0]   cfg_data,
  input  logic [srwc_pkg::ID_W-1:0]     sequence_id,
  input  logic [srwc_pkg::TIME_W-1:0]   now_time,
  input  srwc_pkg::srwc_cmd_t           cmd,
  output srwc_pkg::srwc_stat_t          stat,
  output logic                          done,
  output logic                          accepted,
  output logic [2:0]                    verdict
);
  import srwc_pkg::*;

  logic [TIME_W-1:0]         window;
  logic [ID_W-1:0]           id_reg;
  logic [TIME_W-1:0]         diff;
  logic [TIME_W-1:0]         stamp;
  logic [TIME_W-1:0]         diff_next;
  logic [PTR_W-1:0]          ptr;
  logic [PTR_W-1:0]          cnt;
  logic [PTR_W-1:0]          ins;
  logic                      first_hit;
  logic [PTR_W-1:0]          newest_slot;
  logic [ID_W-1:0]           mem [WINDOW_ENTRIES];
  logic [WINDOW_ENTRIES-1:0] vbits;
  logic [ID_W-1:0]           rdata;
  logic                      rvalid;
  logic [ID_W-1:0]           cur;
  logic                      wr_en;
  logic [PTR_W-1:0]          waddr;
  logic [ID_W-1:0]           wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_data;
    end
  end

  assign stamp     = sequence_id[ID_W-1:ID_W-TIME_W];
  assign diff_next = (now_time >= stamp) ? (now_time - stamp) : (stamp - now_time);

  // never-written entries read as zero
  assign cur = rvalid ? rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_reg <= sequence_id;
      diff   <= diff_next;
    end
    if (cmd.load || cmd.ptr_newest) begin
      ptr <= newest_slot;
    end else if (cmd.ptr_dec) begin
      ptr <= slot_dec(ptr);
    end
    if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 1'b1;
    end
    if (cmd.save_ins) begin
      ins       <= ptr;
      first_hit <= (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot <= '0;
    end else if (cmd.ins_wr) begin
      newest_slot <= slot_inc(newest_slot);
    end
  end

  // shift moves an entry up one slot; insertion lands just above the hit
  assign wr_en = cmd.shift_wr || cmd.ins_wr;
  assign waddr = cmd.ins_wr ? slot_inc(ins) : slot_inc(ptr);
  assign wdata = cmd.ins_wr ? id_reg : cur;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata  <= mem[ptr];
      rvalid <= vbits[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (wr_en) begin
      vbits[waddr] <= 1'b1;
    end
  end

  always_comb begin
    stat           = '0;
    stat.stale     = (window != '0) && (diff > window);
    stat.gt        = (id_reg > cur);
    stat.eq        = (id_reg == cur);
    stat.cnt_zero  = (cnt == '0);
    stat.cnt_last  = (cnt == LAST_SLOT);
    stat.first_hit = first_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      accepted <= cmd.ok;
      verdict  <= cmd.verdict;
    end
  end

  `SRWC_NEVER(a_single_write, clk, rst, cmd.ins_wr && cmd.shift_wr)
  `SRWC_ASSERT(a_newest_moves_on_insert, clk, rst, !$stable(newest_slot) |-> $past(cmd.ins_wr))
  `SRWC_ASSERT(a_accept_verdict, clk, rst,
    (done && accepted) |-> (verdict == VERDICT_NEWEST || verdict == VERDICT_OUT_OF_ORDER))

endmodule
